// File: hdl/tsr_pkg.sv
package tsr_pkg;

  localparam int unsigned RingDepthDef  = 16384;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned StampW        = 32;
  localparam int unsigned SampleW       = 16;

  localparam logic [StampW-1:0] HalfRange = 32'h8000_0000;

  typedef enum logic {
    OP_PUT = 1'b0,
    OP_GET = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WIPE,
    ST_COMMIT
  } state_e;

  // a lies before b, modulo 2^32
  function automatic logic stamp_before(input logic [StampW-1:0] a,
                                        input logic [StampW-1:0] b);
    logic [StampW-1:0] diff;
    diff = a - b;
    return diff > HalfRange;
  endfunction

endpackage

// File: hdl/tsr_ram.sv
module tsr_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: hdl/timestamped_sample_ring_core.sv
// Get: done_o strobes the result next cycle; a get can be taken every cycle when idle.
// Put inside the window: written straight into the ring RAM; a put behind it is dropped.
// Put past newest mark: gap (at most RING_DEPTH) zeroed, then write; one RAM write port.
// First put after reset: the whole ring is swept to zero before the sample is written.
// Reset clears control state only; the ring RAM is swept on the first put.
// Results are a one-cycle strobe; the receiver cannot stall them.
module timestamped_sample_ring_core #(
  parameter int unsigned RING_DEPTH  = tsr_pkg::RingDepthDef,
  parameter int unsigned SAMPLE_BITS = tsr_pkg::SampleBitsDef
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               start,
  output logic                               busy,
  input  logic                               op_i,
  input  logic [tsr_pkg::StampW-1:0]         stamp_i,
  input  logic signed [tsr_pkg::SampleW-1:0] sample_in_i,
  input  logic                               block_last_i,
  output logic                               done_o,
  output logic signed [tsr_pkg::SampleW-1:0] sample_out_o,
  output logic                               silence_o
);

  localparam int unsigned AW = $clog2(RING_DEPTH);
  localparam int unsigned CW = $clog2(RING_DEPTH + 1);
  localparam logic [tsr_pkg::StampW-1:0] Depth32 = tsr_pkg::StampW'(RING_DEPTH);
  localparam logic [CW-1:0] DepthCnt = CW'(RING_DEPTH);

  tsr_pkg::state_e state_q, state_d;

  logic [tsr_pkg::StampW-1:0] newest_q, newest_d;
  logic                       started_q, started_d;
  logic                       inside_q, inside_d;
  logic                       dropped_q, dropped_d;
  logic [AW-1:0]              waddr_q, waddr_d;
  logic [CW-1:0]              remain_q, remain_d;
  logic [AW-1:0]              pend_addr_q, pend_addr_d;
  logic [SAMPLE_BITS-1:0]     pend_data_q, pend_data_d;
  logic                       done_q;
  logic                       silence_q, silence_d;

  logic accept, is_put, is_get;
  logic drop_now, need_wipe, whole_ring;
  logic [tsr_pkg::StampW-1:0] stamp_p1, gap32;
  logic signed [31:0]         wide32;
  logic [SAMPLE_BITS-1:0]     wdata_sample;

  logic                   mem_we, mem_re;
  logic [AW-1:0]          mem_waddr;
  logic [SAMPLE_BITS-1:0] mem_wdata, mem_rdata;
  logic signed [SAMPLE_BITS-1:0] rd_s;
  logic signed [31:0]            rd_ext;

  assign busy   = (state_q != tsr_pkg::ST_IDLE);
  assign accept = start && !busy;
  assign is_put = accept && (tsr_pkg::op_e'(op_i) == tsr_pkg::OP_PUT);
  assign is_get = accept && (tsr_pkg::op_e'(op_i) == tsr_pkg::OP_GET);

  assign stamp_p1     = stamp_i + 32'd1;
  assign gap32        = stamp_i - newest_q;
  assign whole_ring   = !started_q || (gap32 >= Depth32);
  assign wide32       = 32'(sample_in_i);
  assign wdata_sample = wide32[SAMPLE_BITS-1:0];

  // Drop decision is taken on the first word of a block and held for the rest.
  always_comb begin
    if (inside_q) begin
      drop_now = dropped_q;
    end else if (!started_q) begin
      drop_now = 1'b0;
    end else begin
      drop_now = tsr_pkg::stamp_before(stamp_i, newest_q - Depth32);
    end
  end

  assign need_wipe = !started_q || tsr_pkg::stamp_before(newest_q, stamp_i);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (is_put && !drop_now && need_wipe) begin
          state_d = tsr_pkg::ST_WIPE;
        end
      end
      tsr_pkg::ST_WIPE: begin
        if (remain_q == CW'(1)) begin
          state_d = tsr_pkg::ST_COMMIT;
        end
      end
      tsr_pkg::ST_COMMIT: state_d = tsr_pkg::ST_IDLE;
      default:            state_d = tsr_pkg::ST_IDLE;
    endcase
  end

  // Datapath and RAM controls
  always_comb begin
    newest_d    = newest_q;
    started_d   = started_q;
    inside_d    = inside_q;
    dropped_d   = dropped_q;
    waddr_d     = waddr_q;
    remain_d    = remain_q;
    pend_addr_d = pend_addr_q;
    pend_data_d = pend_data_q;
    silence_d   = silence_q;
    mem_we      = 1'b0;
    mem_waddr   = stamp_i[AW-1:0];
    mem_wdata   = wdata_sample;
    mem_re      = is_get;
    unique case (state_q)
      tsr_pkg::ST_IDLE: begin
        if (is_put) begin
          inside_d  = !block_last_i;
          dropped_d = drop_now;
          if (!drop_now) begin
            started_d = 1'b1;
            if (!started_q || tsr_pkg::stamp_before(newest_q, stamp_p1)) begin
              newest_d = stamp_p1;
            end
            if (need_wipe) begin
              waddr_d     = whole_ring ? '0 : newest_q[AW-1:0];
              remain_d    = whole_ring ? DepthCnt : gap32[CW-1:0];
              pend_addr_d = stamp_i[AW-1:0];
              pend_data_d = wdata_sample;
            end else begin
              mem_we = 1'b1;
            end
          end
        end
        if (is_get) begin
          silence_d = !started_q || !tsr_pkg::stamp_before(stamp_i, newest_q) ||
                      !tsr_pkg::stamp_before(newest_q - Depth32, stamp_p1);
        end
      end
      tsr_pkg::ST_WIPE: begin
        mem_we    = 1'b1;
        mem_waddr = waddr_q;
        mem_wdata = '0;
        waddr_d   = waddr_q + AW'(1);
        remain_d  = remain_q - CW'(1);
      end
      tsr_pkg::ST_COMMIT: begin
        mem_we    = 1'b1;
        mem_waddr = pend_addr_q;
        mem_wdata = pend_data_q;
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= tsr_pkg::ST_IDLE;
      newest_q  <= '0;
      started_q <= 1'b0;
      inside_q  <= 1'b0;
      dropped_q <= 1'b0;
      remain_q  <= '0;
      done_q    <= 1'b0;
      silence_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      newest_q  <= newest_d;
      started_q <= started_d;
      inside_q  <= inside_d;
      dropped_q <= dropped_d;
      remain_q  <= remain_d;
      done_q    <= is_get;
      silence_q <= silence_d;
    end
  end

  always_ff @(posedge clk_i) begin
    waddr_q     <= waddr_d;
    pend_addr_q <= pend_addr_d;
    pend_data_q <= pend_data_d;
  end

  tsr_ram #(
    .WIDTH(SAMPLE_BITS),
    .DEPTH(RING_DEPTH)
  ) u_ring (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(stamp_i[AW-1:0]),
    .rdata_o(mem_rdata)
  );

  // Sign-extend the stored word from its stored width
  assign rd_s   = signed'(mem_rdata);
  assign rd_ext = 32'(rd_s);

  assign done_o       = done_q;
  assign silence_o    = silence_q;
  assign sample_out_o = silence_q ? '0 : signed'(rd_ext[tsr_pkg::SampleW-1:0]);

  a_done_not_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobed while the ring is being swept");

  a_put_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == tsr_pkg::OP_PUT) |=> !done_o)
    else $error("put produced a result");

  a_get_before_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && op_i == tsr_pkg::OP_GET && !started_q) |=> (done_o && silence_o))
    else $error("get before first put was not silent");

  a_wipe_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsr_pkg::ST_WIPE) |-> (remain_q != '0))
    else $error("sweep running with no entries left");

  a_wipe_to_commit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == tsr_pkg::ST_WIPE && remain_q == CW'(1)) |=> (state_q == tsr_pkg::ST_COMMIT))
    else $error("sweep did not hand over to the sample write");

endmodule
